### rtl/core/nns_pkg.sv
// nns_pkg: shared types, register indexes and the axis mapping function
// of the nearest-neighbor image scaler. No dependencies.

package nns_pkg;

  localparam int COORD_BITS = 12;
  localparam int CHAN_BITS  = 16;
  localparam int SCALE_BITS = 24;
  localparam int POS_BITS   = COORD_BITS + SCALE_BITS;
  localparam int FRAC_BITS  = 16;
  localparam int BASE_BITS  = POS_BITS - FRAC_BITS;
  localparam int SIZE_BITS  = 8;

  localparam logic [FRAC_BITS-1:0] FRAC_HALF = 16'h8000;

  // queue depth and the count that goes with it
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;
  localparam int QCNT_BITS   = 3;

  // configuration register indexes
  localparam logic [2:0] REG_SOURCE_WIDTH    = 3'd0;
  localparam logic [2:0] REG_SOURCE_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_TARGET_WIDTH    = 3'd2;
  localparam logic [2:0] REG_TARGET_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_INVERSE_SCALE_X = 3'd4;
  localparam logic [2:0] REG_INVERSE_SCALE_Y = 3'd5;

  // source sizes here are already clamped to the frame store
  typedef struct packed {
    logic [SIZE_BITS-1:0]  src_width;
    logic [SIZE_BITS-1:0]  src_height;
    logic [COORD_BITS-1:0] tgt_width;
    logic [COORD_BITS-1:0] tgt_height;
    logic [SCALE_BITS-1:0] inv_x;
    logic [SCALE_BITS-1:0] inv_y;
  } cfg_t;

  typedef struct packed {
    logic                  is_read;
    logic                  err;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic [POS_BITS-1:0]   pos_x;
    logic [POS_BITS-1:0]   pos_y;
    logic [CHAN_BITS-1:0]  luma;
    logic [CHAN_BITS-1:0]  cb;
    logic [CHAN_BITS-1:0]  cr;
  } req_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] luma;
    logic [CHAN_BITS-1:0] cb;
    logic [CHAN_BITS-1:0] cr;
    logic                 status;
  } res_t;

  typedef struct packed {
    logic                 full;
    logic                 empty;
    logic [QCNT_BITS-1:0] count;
  } fifo_stat_t;

  // Q20.16 position to source index: round up past one half unless already on
  // the last index, then clamp to the last index.
  function automatic logic [SIZE_BITS-1:0] map_axis(input logic [POS_BITS-1:0] pos,
                                                    input logic [SIZE_BITS-1:0] size);
    logic [BASE_BITS:0] base;
    logic [BASE_BITS:0] lim;
    base = {1'b0, pos[POS_BITS-1:FRAC_BITS]};
    lim  = (BASE_BITS+1)'(size);
    if (pos[FRAC_BITS-1:0] > FRAC_HALF && (base + 1'b1) < lim) begin
      base = base + 1'b1;
    end
    if (base >= lim) begin
      base = lim - 1'b1;
    end
    return base[SIZE_BITS-1:0];
  endfunction

endpackage

### rtl/core/nns_ram.sv
// nns_ram: generic single-port RAM with registered read data.
// No dependencies.

module nns_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### rtl/core/nns_fifo.sv
// nns_fifo: short register queue, QUEUE_DEPTH entries, with full/empty/count.
// Depends on nns_pkg.

module nns_fifo #(
  parameter int WIDTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [WIDTH-1:0]   wdata,
  input  logic               pop,
  output logic [WIDTH-1:0]   rdata,
  output nns_pkg::fifo_stat_t stat
);

  import nns_pkg::*;

  logic [WIDTH-1:0]     mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign stat.full  = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign stat.count = count;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

### rtl/core/nns_front.sv
// nns_front: input beat acceptance, range check and the two coordinate
// products; its request goes straight into the middle queue. Depends on nns_pkg.

module nns_front (
  input  nns_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           func,
  input  logic [11:0]    column,
  input  logic [11:0]    line,
  input  logic [15:0]    luma_in,
  input  logic [15:0]    cb_in,
  input  logic [15:0]    cr_in,
  input  logic           queue_full,
  output logic           push,
  output nns_pkg::req_t  req
);

  import nns_pkg::*;

  logic wr_err;
  logic rd_err;

  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full;

  assign wr_err = (column >= COORD_BITS'(cfg.src_width)) ||
                  (line >= COORD_BITS'(cfg.src_height));
  assign rd_err = (cfg.src_width == '0) || (cfg.src_height == '0) ||
                  (column >= cfg.tgt_width) || (line >= cfg.tgt_height);

  always_comb begin
    req.is_read = func;
    req.err     = func ? rd_err : wr_err;
    req.col     = column;
    req.row     = line;
    req.pos_x   = POS_BITS'(column) * POS_BITS'(cfg.inv_x);
    req.pos_y   = POS_BITS'(line) * POS_BITS'(cfg.inv_y);
    req.luma    = luma_in;
    req.cb      = cb_in;
    req.cr      = cr_in;
  end

endmodule

### rtl/core/nns_back.sv
// nns_back: drains the middle queue, maps positions to source indexes and
// runs the frame store access; results go to the output queue.
// Depends on nns_pkg, nns_ram.

module nns_back #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int PIXEL_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  nns_pkg::cfg_t       cfg,
  input  nns_pkg::fifo_stat_t q_stat,
  input  nns_pkg::req_t       q_head,
  output logic                q_pop,
  input  nns_pkg::fifo_stat_t out_stat,
  output logic                out_push,
  output nns_pkg::res_t       out_res
);

  import nns_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);

  logic [QCNT_BITS-1:0]   in_flight;
  logic [SIZE_BITS-1:0]   x_next;
  logic [SIZE_BITS-1:0]   y_next;

  logic                   s1_valid;
  logic                   s1_read;
  logic                   s1_err;
  logic [SIZE_BITS-1:0]   s1_x;
  logic [SIZE_BITS-1:0]   s1_y;
  logic [3*PIXEL_BITS-1:0] s1_pix;

  logic                   s2_valid;
  logic                   s2_read;
  logic                   s2_err;

  logic [AW-1:0]          addr;
  logic                   ram_we;
  logic                   ram_re;
  logic [3*PIXEL_BITS-1:0] ram_rdata;

  // reserve room in the output queue for every beat still in the pipe
  assign in_flight = QCNT_BITS'(s1_valid) + QCNT_BITS'(s2_valid) + out_stat.count;
  assign q_pop     = !q_stat.empty && (in_flight < QCNT_BITS'(QUEUE_DEPTH));

  // a valid write coordinate is below the clamped source size, so 8 bits hold it
  assign x_next = q_head.is_read ? map_axis(q_head.pos_x, cfg.src_width)
                                 : q_head.col[SIZE_BITS-1:0];
  assign y_next = q_head.is_read ? map_axis(q_head.pos_y, cfg.src_height)
                                 : q_head.row[SIZE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= q_pop;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_read <= q_head.is_read;
      s1_err  <= q_head.err;
      s1_x    <= x_next;
      s1_y    <= y_next;
      s1_pix  <= {PIXEL_BITS'(q_head.cr), PIXEL_BITS'(q_head.cb), PIXEL_BITS'(q_head.luma)};
    end
    s2_read <= s1_read;
    s2_err  <= s1_err;
  end

  assign addr   = AW'(s1_y) * ROW_STRIDE + AW'(s1_x);
  assign ram_we = s1_valid && !s1_read && !s1_err;
  assign ram_re = s1_valid && s1_read && !s1_err;

  nns_ram #(
    .WIDTH (3 * PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (addr),
    .wdata (s1_pix),
    .rdata (ram_rdata)
  );

  assign out_push = s2_valid;

  always_comb begin
    out_res.status = s2_err;
    if (s2_read && !s2_err) begin
      out_res.luma = CHAN_BITS'(ram_rdata[PIXEL_BITS-1:0]);
      out_res.cb   = CHAN_BITS'(ram_rdata[2*PIXEL_BITS-1:PIXEL_BITS]);
      out_res.cr   = CHAN_BITS'(ram_rdata[3*PIXEL_BITS-1:2*PIXEL_BITS]);
    end else begin
      out_res.luma = '0;
      out_res.cb   = '0;
      out_res.cr   = '0;
    end
  end

endmodule

### rtl/core/nearest_neighbor_image_scaler.sv
// nearest_neighbor_image_scaler: frame store with nearest-neighbor resized reads.
// Path: a result beat shows on m_axis once its input beat has passed through the
// middle queue, index/address stage, registered frame store read and output queue.
// Throughput: one beat per cycle unless m_axis stalls; decoupled by 4-entry queues.
// Reset: queues and pipe empty, registers at defaults; frame store not cleared.
// Depends on nns_pkg, nns_fifo, nns_front, nns_back, nns_ram.

module nearest_neighbor_image_scaler #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int PIXEL_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // column[11:0], line[23:12], luma_in, cb_in, cr_in
  input  logic [0:0]  s_axis_tuser,  // func
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // luma_out[15:0], cb_out[31:16], cr_out[47:32]
  output logic [0:0]  m_axis_tuser   // status
);

  import nns_pkg::*;

  logic [7:0]  source_width;
  logic [7:0]  source_height;
  logic [11:0] target_width;
  logic [11:0] target_height;
  logic [23:0] inverse_scale_x;
  logic [23:0] inverse_scale_y;

  cfg_t       cfg;
  req_t       front_req;
  logic       front_push;
  fifo_stat_t q_stat;
  logic [$bits(req_t)-1:0] q_rdata;
  logic       q_pop;
  fifo_stat_t out_stat;
  logic       out_push;
  res_t       out_res;
  logic [$bits(res_t)-1:0] out_rdata;
  res_t       out_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width    <= 8'd128;
      source_height   <= 8'd128;
      target_width    <= 12'd128;
      target_height   <= 12'd128;
      inverse_scale_x <= 24'd65536;
      inverse_scale_y <= 24'd65536;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH:    source_width    <= cfg_data[7:0];
        REG_SOURCE_HEIGHT:   source_height   <= cfg_data[7:0];
        REG_TARGET_WIDTH:    target_width    <= cfg_data[11:0];
        REG_TARGET_HEIGHT:   target_height   <= cfg_data[11:0];
        REG_INVERSE_SCALE_X: inverse_scale_x <= cfg_data;
        REG_INVERSE_SCALE_Y: inverse_scale_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp source sizes to the frame store
  always_comb begin
    cfg.src_width  = (32'(source_width) > MAX_WIDTH) ? SIZE_BITS'(MAX_WIDTH) : source_width;
    cfg.src_height = (32'(source_height) > MAX_HEIGHT) ? SIZE_BITS'(MAX_HEIGHT)
                                                       : source_height;
    cfg.tgt_width  = target_width;
    cfg.tgt_height = target_height;
    cfg.inv_x      = inverse_scale_x;
    cfg.inv_y      = inverse_scale_y;
  end

  nns_front u_front (
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .func       (s_axis_tuser[0]),
    .column     (s_axis_tdata[11:0]),
    .line       (s_axis_tdata[23:12]),
    .luma_in    (s_axis_tdata[39:24]),
    .cb_in      (s_axis_tdata[55:40]),
    .cr_in      (s_axis_tdata[71:56]),
    .queue_full (q_stat.full),
    .push       (front_push),
    .req        (front_req)
  );

  nns_fifo #(
    .WIDTH ($bits(req_t))
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .wdata (front_req),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  nns_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_stat   (q_stat),
    .q_head   (req_t'(q_rdata)),
    .q_pop    (q_pop),
    .out_stat (out_stat),
    .out_push (out_push),
    .out_res  (out_res)
  );

  nns_fifo #(
    .WIDTH ($bits(res_t))
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_res),
    .pop   (m_axis_tvalid && m_axis_tready),
    .rdata (out_rdata),
    .stat  (out_stat)
  );

  assign out_head        = res_t'(out_rdata);
  assign m_axis_tvalid   = !out_stat.empty;
  assign m_axis_tdata    = {out_head.cr, out_head.cb, out_head.luma};
  assign m_axis_tuser[0] = out_head.status;

endmodule
